// ===== hw/rtl/sjv_pkg.sv =====
// Package for the simplified JSON syntax validator.
// Holds the sizing constants, character codes and the parse types.
// No dependencies.
`default_nettype none

package sjv_pkg;

  // Deepest nesting the kind stack can hold.
  localparam int MAX_NESTING = 64;
  // Open-level counter must be able to hold MAX_NESTING itself.
  localparam int LEVEL_W     = $clog2(MAX_NESTING + 1);
  localparam int LIMIT_W     = 7;
  localparam int CHAR_W      = 8;
  localparam int VERDICT_W   = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

  // Character codes used by the grammar.
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE    = 8'h31;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;

  typedef enum logic [3:0] {
    PH_VALUE    = 4'd0,
    PH_ARR_OPEN = 4'd1,
    PH_OBJ_OPEN = 4'd2,
    PH_MINUS    = 4'd3,
    PH_ZERO     = 4'd4,
    PH_DIGITS   = 4'd5,
    PH_AFTER    = 4'd6,
    PH_KEY_PRE  = 4'd7,
    PH_KEY      = 4'd8,
    PH_KEY_POST = 4'd9
  } phase_e;

  typedef enum logic {
    KIND_ARRAY  = 1'b0,
    KIND_OBJECT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_SYNTAX = 2'd1,
    FAULT_DEEP   = 2'd2
  } fault_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ACCEPTED   = 2'd0,
    VERDICT_SYNTAX     = 2'd1,
    VERDICT_TOO_DEEP   = 2'd2,
    VERDICT_INCOMPLETE = 2'd3
  } verdict_e;

endpackage

`default_nettype wire

// ===== hw/rtl/sjv_if.sv =====
// Handshake channels of the simplified JSON syntax validator.
// Byte input, verdict output and limit write channels; uses sjv_pkg.
`default_nettype none

// One document byte per item.
interface sjv_in_if import sjv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              final_byte;

  modport source (output valid, output char_code, output final_byte, input ready);
  modport sink   (input valid, input char_code, input final_byte, output ready);
endinterface

// One verdict per document.
interface sjv_out_if import sjv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

// Write channel of the nesting limit register.
interface sjv_cfg_if import sjv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] nesting_limit;

  modport source (output valid, output nesting_limit, input ready);
  modport sink   (input valid, input nesting_limit, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/simplified_json_syntax_validator.sv =====
// Top level of the simplified JSON syntax validator.
// Depends on sjv_pkg and the channel interfaces in sjv_if.sv.
`default_nettype none

// The validator takes one document byte per item and one item per clock
// cycle while its input is ready, with no gaps between bytes or between
// documents. Each byte updates the parse phase, the open-level count and a
// shift register of container kinds in the cycle it is accepted; that state
// update is what sets the rate of one byte per cycle. The byte flagged as
// final produces one verdict, which is registered into the output in the
// cycle after acceptance when no earlier verdict is still waiting there; all
// other bytes produce nothing. A two-entry result buffer lets input continue
// while a verdict waits to be taken; input stalls only when both entries
// are full. There is no clearing pass after reset. The nesting limit is
// written through its own channel, which is always ready, and should only
// be written between documents.
module simplified_json_syntax_validator import sjv_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sjv_in_if.sink    in_i,
  sjv_out_if.source out_o,
  sjv_cfg_if.sink   cfg_i
);

  localparam int CMP_W = (LEVEL_W > LIMIT_W) ? LEVEL_W : LIMIT_W;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_SYNTAX,
    ACT_SET,
    ACT_START,
    ACT_KEY_PRE,
    ACT_AFTER,
    ACT_OPEN,
    ACT_CLOSE
  } act_e;

  // Character classes.
  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF};
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_nonzero(input logic [CHAR_W-1:0] c);
    return c inside {[CH_ONE:CH_NINE]};
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return c inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]};
  endfunction

  // Registers.
  logic [LIMIT_W-1:0]     limit_q;
  phase_e                 phase_q, phase_d;
  fault_e                 fault_q, fault_d;
  logic [LEVEL_W-1:0]     open_q, open_d;
  logic [MAX_NESTING-1:0] stack_q, stack_d;
  logic                   out_v_q, out_v_d;
  verdict_e               out_q, out_d;
  logic                   skid_v_q, skid_v_d;
  verdict_e               skid_q, skid_d;

  // Per-byte parse results.
  phase_e             phase_c;
  fault_e             fault_c;
  logic [LEVEL_W-1:0] open_c;
  logic               push_c;
  logic               pop_c;
  kind_e              kind_c;
  act_e               act;
  phase_e             target;
  verdict_e           verdict_c;
  logic               top_obj;
  logic               too_deep;
  logic [CHAR_W-1:0]  ch;
  logic               in_fire;
  logic               out_pop;
  logic               res_push;

  assign ch       = in_i.char_code;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_pop  = out_v_q && out_o.ready;
  assign res_push = in_fire && in_i.final_byte;
  assign top_obj  = (stack_q[0] == KIND_OBJECT);

  // Opening a container is refused once the count reaches the smaller of
  // the written limit and the stack depth.
  assign too_deep = (CMP_W'(open_q) >= CMP_W'(limit_q)) ||
                    (CMP_W'(open_q) >= CMP_W'(MAX_NESTING));

  // Limit register.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.nesting_limit;
    end
  end

  // Parse step for the current byte: pick an action from the phase, then
  // resolve value starts, key starts and separators, then open or close.
  always_comb begin
    act     = ACT_NONE;
    target  = phase_q;
    kind_c  = KIND_ARRAY;
    phase_c = phase_q;
    fault_c = fault_q;
    open_c  = open_q;
    push_c  = 1'b0;
    pop_c   = 1'b0;

    if (fault_q == FAULT_NONE) begin
      case (phase_q)
        PH_VALUE: begin
          act = ACT_START;
        end
        PH_ARR_OPEN: begin
          if (ch == CH_RBRACK) begin
            act    = ACT_CLOSE;
            kind_c = KIND_ARRAY;
          end else begin
            act = ACT_START;
          end
        end
        PH_OBJ_OPEN: begin
          if (ch == CH_RBRACE) begin
            act    = ACT_CLOSE;
            kind_c = KIND_OBJECT;
          end else begin
            act = ACT_KEY_PRE;
          end
        end
        PH_MINUS: begin
          if (is_nonzero(ch)) begin
            act    = ACT_SET;
            target = PH_DIGITS;
          end else begin
            act = ACT_SYNTAX;
          end
        end
        PH_ZERO: begin
          act = is_digit(ch) ? ACT_SYNTAX : ACT_AFTER;
        end
        PH_DIGITS: begin
          act = is_digit(ch) ? ACT_NONE : ACT_AFTER;
        end
        PH_AFTER: begin
          act = ACT_AFTER;
        end
        PH_KEY_PRE: begin
          act = ACT_KEY_PRE;
        end
        PH_KEY: begin
          if (is_alpha(ch)) begin
            act    = ACT_SET;
            target = PH_KEY;
          end else if (is_blank(ch)) begin
            act    = ACT_SET;
            target = PH_KEY_POST;
          end else if (ch == CH_COLON) begin
            act    = ACT_SET;
            target = PH_VALUE;
          end else begin
            act = ACT_SYNTAX;
          end
        end
        PH_KEY_POST: begin
          if (ch == CH_COLON) begin
            act    = ACT_SET;
            target = PH_VALUE;
          end else if (!is_blank(ch)) begin
            act = ACT_SYNTAX;
          end
        end
        default: begin
          act = ACT_SYNTAX;
        end
      endcase
    end

    // Start of a value.
    if (act == ACT_START) begin
      act = ACT_SET;
      if (is_blank(ch)) begin
        target = PH_VALUE;
      end else if (is_nonzero(ch)) begin
        target = PH_DIGITS;
      end else if (ch == CH_ZERO) begin
        target = PH_ZERO;
      end else if (ch == CH_MINUS) begin
        target = PH_MINUS;
      end else if (ch == CH_LBRACK) begin
        act    = ACT_OPEN;
        kind_c = KIND_ARRAY;
      end else if (ch == CH_LBRACE) begin
        act    = ACT_OPEN;
        kind_c = KIND_OBJECT;
      end else begin
        act = ACT_SYNTAX;
      end
    end

    // Start of a key.
    if (act == ACT_KEY_PRE) begin
      act = ACT_SET;
      if (is_blank(ch)) begin
        target = PH_KEY_PRE;
      end else if (is_alpha(ch)) begin
        target = PH_KEY;
      end else begin
        act = ACT_SYNTAX;
      end
    end

    // After a complete value: blanks, a separator or a closer.
    if (act == ACT_AFTER) begin
      act    = ACT_SET;
      target = PH_AFTER;
      if (is_blank(ch)) begin
        target = PH_AFTER;
      end else if (open_q == '0) begin
        act = ACT_SYNTAX;
      end else if (ch == CH_COMMA) begin
        target = top_obj ? PH_KEY_PRE : PH_VALUE;
      end else if (ch == CH_RBRACK) begin
        act    = ACT_CLOSE;
        kind_c = KIND_ARRAY;
      end else if (ch == CH_RBRACE) begin
        act    = ACT_CLOSE;
        kind_c = KIND_OBJECT;
      end else begin
        act = ACT_SYNTAX;
      end
    end

    // Apply the resolved action.
    case (act)
      ACT_SET: begin
        phase_c = target;
      end
      ACT_SYNTAX: begin
        fault_c = FAULT_SYNTAX;
      end
      ACT_OPEN: begin
        if (too_deep) begin
          fault_c = FAULT_DEEP;
        end else begin
          push_c  = 1'b1;
          open_c  = open_q + LEVEL_W'(1);
          phase_c = (kind_c == KIND_OBJECT) ? PH_OBJ_OPEN : PH_ARR_OPEN;
        end
      end
      ACT_CLOSE: begin
        if ((open_q == '0) || (stack_q[0] != kind_c)) begin
          fault_c = FAULT_SYNTAX;
        end else begin
          pop_c   = 1'b1;
          open_c  = open_q - LEVEL_W'(1);
          phase_c = PH_AFTER;
        end
      end
      default: begin
      end
    endcase
  end

  // Verdict of a document that ends on this byte.
  always_comb begin
    case (fault_c)
      FAULT_SYNTAX: verdict_c = VERDICT_SYNTAX;
      FAULT_DEEP:   verdict_c = VERDICT_TOO_DEEP;
      default: begin
        if ((open_c == '0) &&
            ((phase_c == PH_AFTER) || (phase_c == PH_DIGITS) || (phase_c == PH_ZERO))) begin
          verdict_c = VERDICT_ACCEPTED;
        end else begin
          verdict_c = VERDICT_INCOMPLETE;
        end
      end
    endcase
  end

  // Next parse state; a final byte returns the parser to its start.
  always_comb begin
    phase_d = phase_q;
    fault_d = fault_q;
    open_d  = open_q;
    stack_d = stack_q;
    if (in_fire) begin
      if (in_i.final_byte) begin
        phase_d = PH_VALUE;
        fault_d = FAULT_NONE;
        open_d  = '0;
      end else begin
        phase_d = phase_c;
        fault_d = fault_c;
        open_d  = open_c;
        if (push_c) begin
          stack_d = (stack_q << 1) | MAX_NESTING'(kind_c);
        end else if (pop_c) begin
          stack_d = stack_q >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VALUE;
      fault_q <= FAULT_NONE;
      open_q  <= '0;
    end else begin
      phase_q <= phase_d;
      fault_q <= fault_d;
      open_q  <= open_d;
    end
  end

  // Kind stack, innermost container in bit 0.
  always_ff @(posedge clk_i) begin
    stack_q <= stack_d;
  end

  // Two-entry result buffer: output register with a skid entry behind it.
  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || out_pop) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = res_push;
        skid_d   = verdict_c;
      end else begin
        out_d   = verdict_c;
        out_v_d = res_push;
      end
    end else if (res_push) begin
      skid_d   = verdict_c;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_i.ready    = !skid_v_q;
  assign out_o.valid   = out_v_q;
  assign out_o.verdict = out_q;

  // Assertions.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry holds a verdict while the output register is empty");

  a_levels_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(open_q) <= CMP_W'(MAX_NESTING))
    else $error("open level count beyond stack depth");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> (open_q == '0 && phase_q == PH_VALUE && fault_q == FAULT_NONE))
    else $error("parser not returned to start after final byte");

  a_fault_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_i.final_byte && fault_q != FAULT_NONE) |=> $stable(fault_q))
    else $error("latched fault changed before the final byte");

  a_verdict_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !out_v_q) |=> out_v_q)
    else $error("verdict of a final byte not presented");

endmodule

`default_nettype wire
